>>> hdl/isms_pkg.sv
// Package for the ink stroke midpoint smoother: point, vertex, segment and
// batch types, plus the operation and point-count codes.
// No dependencies.
`default_nettype none

package isms_pkg;

    // Operation codes carried in the point transfer.
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Saturating count of distinct points seen in the current stroke.
    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_TWO  = 2'd2;
    localparam logic [1:0] SEEN_MANY = 2'd3;

    // Segment kinds.
    localparam logic SEG_PROVISIONAL = 1'b0;
    localparam logic SEG_COMMITTED   = 1'b1;

    // Number of segments one point can produce.
    localparam int unsigned MAX_SEGS = 3;

    typedef struct packed {
        logic               op;
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic        [15:0] point_radius;
        logic               want_provisional;
    } point_t;

    typedef struct packed {
        logic               committed;
        logic signed [23:0] from_x;
        logic signed [23:0] from_y;
        logic        [15:0] from_radius;
        logic signed [23:0] to_x;
        logic signed [23:0] to_y;
        logic        [15:0] to_radius;
        logic               last_of_run;
    } seg_t;

    // Geometry of one stored point.
    typedef struct packed {
        logic [23:0] x;
        logic [23:0] y;
        logic [15:0] r;
    } vtx_t;

    // Segments produced by one point, in delivery order from index 0.
    typedef struct packed {
        logic [1:0]               count;
        seg_t [MAX_SEGS-1:0]      segs;
    } batch_t;

endpackage

`default_nettype wire

>>> hdl/ink_stroke_midpoint_smoother.sv
// Top level of the ink stroke midpoint smoother.
// Depends on isms_pkg, isms_core and isms_out.
//
// Usage:
//   Point channel (point_valid, point_stall, point): one transfer carries a
//   stroke point with its operation (append or finish) and the provisional
//   tail request. Segment channel (seg_valid, seg_stall, seg): each transfer
//   carries one segment; last_of_run marks the final segment of a point.
//   A point produces zero to three segments.
//   A point is first held in the holding register; its segments are then
//   loaded into a three-entry result bank, whose head entry is offered on
//   the segment channel.
//   Throughput: one point per cycle while points produce no segments;
//   otherwise one segment per cycle while the receiver does not stall.
//   The result bank's single output port sets this rate.
//   The holding register accepts the next point while segments still wait.
//   When the receiver stalls, the current segment holds; once the holding
//   register is occupied and the bank cannot take its batch, point_stall rises.
//   Reset clears the point count and empties both stages; stored points
//   are rewritten by the first point of the next stroke.
`default_nettype none

module ink_stroke_midpoint_smoother (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             point_valid,
    output logic                  point_stall,
    input  wire isms_pkg::point_t point,
    output logic                  seg_valid,
    input  wire logic             seg_stall,
    output isms_pkg::seg_t        seg
);
    import isms_pkg::*;

    logic   batch_valid;
    logic   batch_load;
    batch_t batch;

    // Point holding, stroke state and geometry.
    isms_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .batch_valid (batch_valid),
        .batch_load  (batch_load),
        .batch       (batch)
    );

    // Result bank and segment delivery.
    isms_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .batch_valid (batch_valid),
        .batch_load  (batch_load),
        .batch       (batch),
        .seg_valid   (seg_valid),
        .seg_stall   (seg_stall),
        .seg         (seg)
    );

endmodule

`default_nettype wire

>>> hdl/isms_core.sv
// Holding register for the incoming point, the stroke state and the
// single-pass curve geometry. Produces one batch of segments per point.
// Depends on isms_pkg.
`default_nettype none

module isms_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            point_valid,
    output logic                 point_stall,
    input  wire isms_pkg::point_t point,
    output logic                 batch_valid,
    input  wire logic            batch_load,
    output isms_pkg::batch_t     batch
);
    import isms_pkg::*;

    logic        hold_valid_reg;
    point_t      hold_reg;
    vtx_t        stable_reg;
    vtx_t        stable_next;
    vtx_t        recent_reg;
    vtx_t        recent_next;
    logic [1:0]  seen_reg;
    logic [1:0]  seen_next;
    logic [1:0]  seen_mid;
    logic        advance;
    logic        finish;
    logic        want;
    logic        same;
    logic        commit;
    vtx_t        p;
    vtx_t        end_pt;
    vtx_t        mid_pt;
    vtx_t        tail_from;

    // Floor of the average of two points.
    function automatic vtx_t mid_vtx(vtx_t a, vtx_t b);
        logic [24:0] sx;
        logic [24:0] sy;
        logic [16:0] sr;
        vtx_t        m;
        sx = {a.x[23], a.x} + {b.x[23], b.x};
        sy = {a.y[23], a.y} + {b.y[23], b.y};
        sr = {1'b0, a.r} + {1'b0, b.r};
        m.x = sx[24:1];
        m.y = sy[24:1];
        m.r = sr[16:1];
        return m;
    endfunction

    // Middle of the quadratic curve: floor((s + 2c + e) / 4).
    function automatic vtx_t curve_vtx(vtx_t s, vtx_t c, vtx_t e);
        logic [25:0] qx;
        logic [25:0] qy;
        logic [17:0] qr;
        vtx_t        q;
        qx = {{2{s.x[23]}}, s.x} + {c.x[23], c.x, 1'b0} + {{2{e.x[23]}}, e.x};
        qy = {{2{s.y[23]}}, s.y} + {c.y[23], c.y, 1'b0} + {{2{e.y[23]}}, e.y};
        qr = {2'b00, s.r} + {1'b0, c.r, 1'b0} + {2'b00, e.r};
        q.x = qx[25:2];
        q.y = qy[25:2];
        q.r = qr[17:2];
        return q;
    endfunction

    function automatic seg_t make_seg(logic kind, vtx_t a, vtx_t b, logic last);
        seg_t s;
        s.committed   = kind;
        s.from_x      = a.x;
        s.from_y      = a.y;
        s.from_radius = a.r;
        s.to_x        = b.x;
        s.to_y        = b.y;
        s.to_radius   = b.r;
        s.last_of_run = last;
        return s;
    endfunction

    // The held point moves on when the result bank can take its batch.
    assign advance     = hold_valid_reg && batch_load;
    assign point_stall = hold_valid_reg && !batch_load;
    assign batch_valid = hold_valid_reg;

    // Holding register for the accepted point.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (!point_stall)
        begin
            hold_valid_reg <= point_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (point_valid && !point_stall)
        begin
            hold_reg <= point;
        end
    end

    // Geometry of the held point and the curve points derived from it.
    always_comb
    begin
        p.x    = hold_reg.point_x;
        p.y    = hold_reg.point_y;
        p.r    = hold_reg.point_radius;
        finish = (hold_reg.op == OP_FINISH);
        want   = hold_reg.want_provisional | finish;
        same   = (recent_reg == p);
        end_pt = mid_vtx(recent_reg, p);
        mid_pt = curve_vtx(stable_reg, recent_reg, end_pt);
    end

    // Next stroke state.
    always_comb
    begin
        stable_next = stable_reg;
        recent_next = recent_reg;
        seen_mid    = seen_reg;
        commit      = 1'b0;
        case (seen_reg)
            SEEN_NONE:
            begin
                stable_next = p;
                recent_next = p;
                seen_mid    = SEEN_ONE;
            end
            SEEN_ONE:
            begin
                if (!same)
                begin
                    recent_next = p;
                    seen_mid    = SEEN_TWO;
                end
            end
            SEEN_TWO, SEEN_MANY:
            begin
                if (!same)
                begin
                    commit      = 1'b1;
                    stable_next = end_pt;
                    recent_next = p;
                    seen_mid    = SEEN_MANY;
                end
            end
            default:
            begin
                seen_mid = seen_reg;
            end
        endcase
        seen_next = finish ? SEEN_NONE : seen_mid;
        tail_from = (seen_mid == SEEN_ONE) ? recent_next : stable_next;
    end

    // Segments in delivery order: any two committed halves, then any tail.
    always_comb
    begin
        if (commit)
        begin
            batch.count   = want ? 2'd3 : 2'd2;
            batch.segs[0] = make_seg(SEG_COMMITTED, stable_reg, mid_pt, 1'b0);
        end
        else
        begin
            batch.count   = want ? 2'd1 : 2'd0;
            batch.segs[0] = make_seg(finish, tail_from, recent_next, 1'b1);
        end
        batch.segs[1] = make_seg(SEG_COMMITTED, mid_pt, end_pt, !want);
        batch.segs[2] = make_seg(finish, tail_from, recent_next, 1'b1);
    end

    // Stroke state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= SEEN_NONE;
        end
        else if (advance)
        begin
            seen_reg <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stable_reg <= stable_next;
            recent_reg <= recent_next;
        end
    end

    // A finished stroke always restarts from an empty count.
    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && finish) |=> (seen_reg == SEEN_NONE))
        else $error("point count not cleared after finish");

    // A point held back is still present on the next cycle.
    a_hold_kept: assert property (@(posedge clk) disable iff (!rst_n)
        point_stall |=> hold_valid_reg)
        else $error("held point lost while stalled");

endmodule

`default_nettype wire

>>> hdl/isms_out.sv
// Result bank: takes a batch of up to three segments and delivers them
// one transfer per cycle while the segment channel is not stalled.
// Depends on isms_pkg.
`default_nettype none

module isms_out (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             batch_valid,
    output logic                  batch_load,
    input  wire isms_pkg::batch_t batch,
    output logic                  seg_valid,
    input  wire logic             seg_stall,
    output isms_pkg::seg_t        seg
);
    import isms_pkg::*;

    seg_t [MAX_SEGS-1:0] entry_reg;
    logic [1:0]          cnt_reg;
    logic                drain;
    logic                load;

    // The bank takes a new batch when empty or when its last entry leaves.
    assign seg_valid  = (cnt_reg != 2'd0);
    assign seg        = entry_reg[0];
    assign drain      = seg_valid && !seg_stall;
    assign batch_load = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && !seg_stall);
    assign load       = batch_valid && batch_load;

    // Entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= batch.count;
        end
        else if (drain)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Entries shift towards the head as each one is transferred.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= batch.segs;
        end
        else if (drain)
        begin
            entry_reg[0] <= entry_reg[1];
            entry_reg[1] <= entry_reg[2];
        end
    end

    // The run marker sits on exactly the final entry of a batch.
    a_last_marker: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid |-> (seg.last_of_run == (cnt_reg == 2'd1)))
        else $error("last_of_run does not match remaining entries");

    // A batch is refused only while the bank still holds segments.
    a_refuse_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (batch_valid && !batch_load) |-> seg_valid)
        else $error("batch refused with an empty bank");

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the ink stroke midpoint smoother.
// Depends on isms_pkg and ink_stroke_midpoint_smoother; predicts every segment
// in the bench and checks each segment transfer against the oldest prediction.

module testbench;

    import isms_pkg::*;

    // Geometry of one point as the predictor holds it.
    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic        [15:0] r;
    } spot_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   point_valid = 1'b0;
    logic   point_stall;
    point_t point = '0;
    logic   seg_valid;
    logic   seg_stall = 1'b0;
    seg_t   seg;

    // Predictor state: stable point, most recent distinct point, point count.
    spot_t      anchor_pt;
    spot_t      recent_pt;
    logic [1:0] seen_count = SEEN_NONE;

    seg_t due_segments[$];
    seg_t wanted_seg;
    int   error_count = 0;

    // Idling controls, in percent per cycle, and the receiver hold-off request.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request = 0;
    int hold_left = 0;

    ink_stroke_midpoint_smoother uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .seg_valid   (seg_valid),
        .seg_stall   (seg_stall),
        .seg         (seg)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Builds the segment expected between two points.
    function automatic seg_t make_seg(logic kind, spot_t a, spot_t b);
        seg_t s;
        s.committed   = kind;
        s.from_x      = a.x;
        s.from_y      = a.y;
        s.from_radius = a.r;
        s.to_x        = b.x;
        s.to_y        = b.y;
        s.to_radius   = b.r;
        s.last_of_run = 1'b0;
        return s;
    endfunction

    function automatic string seg_text(seg_t s);
        return $sformatf("c=%0b from=(%0d,%0d,%0d) to=(%0d,%0d,%0d) last=%0b",
                         s.committed, s.from_x, s.from_y, s.from_radius,
                         s.to_x, s.to_y, s.to_radius, s.last_of_run);
    endfunction

    function automatic point_t make_point(logic op, int x, int y, int r, logic want);
        point_t p;
        p.op               = op;
        p.point_x          = 24'(x);
        p.point_y          = 24'(y);
        p.point_radius     = 16'(r);
        p.want_provisional = want;
        return p;
    endfunction

    // Works out the segments that one accepted point produces and queues them.
    task automatic smooth_point(input point_t p);
        spot_t              cur;
        spot_t              end_pt;
        spot_t              mid_pt;
        logic               finishing;
        logic               want;
        logic signed [24:0] sum_x;
        logic signed [24:0] sum_y;
        logic        [16:0] sum_r;
        logic signed [26:0] wide_x;
        logic signed [26:0] wide_y;
        logic        [17:0] wide_r;
        seg_t               batch[$];
        cur.x = p.point_x;
        cur.y = p.point_y;
        cur.r = p.point_radius;
        finishing = (p.op == OP_FINISH);
        want = p.want_provisional | finishing;

        if (seen_count == SEEN_NONE)
        begin
            anchor_pt = cur;
            recent_pt = cur;
            seen_count = SEEN_ONE;
        end
        else if (cur != recent_pt)
        begin
            if (seen_count == SEEN_ONE)
            begin
                recent_pt = cur;
                seen_count = SEEN_TWO;
            end
            else
            begin
                // Midpoint of the recent and new points, rounded down.
                sum_x = 25'(recent_pt.x) + 25'(cur.x);
                sum_y = 25'(recent_pt.y) + 25'(cur.y);
                sum_r = 17'(recent_pt.r) + 17'(cur.r);
                end_pt.x = 24'(sum_x >>> 1);
                end_pt.y = 24'(sum_y >>> 1);
                end_pt.r = 16'(sum_r >> 1);
                // Middle of the quadratic curve, full sum shifted right by two.
                wide_x = 27'(anchor_pt.x) + (27'(recent_pt.x) <<< 1) + 27'(end_pt.x);
                wide_y = 27'(anchor_pt.y) + (27'(recent_pt.y) <<< 1) + 27'(end_pt.y);
                wide_r = 18'(anchor_pt.r) + (18'(recent_pt.r) << 1) + 18'(end_pt.r);
                mid_pt.x = 24'(wide_x >>> 2);
                mid_pt.y = 24'(wide_y >>> 2);
                mid_pt.r = 16'(wide_r >> 2);
                batch = {batch, make_seg(SEG_COMMITTED, anchor_pt, mid_pt)};
                batch = {batch, make_seg(SEG_COMMITTED, mid_pt, end_pt)};
                anchor_pt = end_pt;
                recent_pt = cur;
                if (seen_count != SEEN_MANY)
                    seen_count = seen_count + 2'd1;
            end
        end

        // Tail segment; a single point gives a degenerate one.
        if (want)
            batch = {batch, make_seg(finishing ? SEG_COMMITTED : SEG_PROVISIONAL,
                                     (seen_count == SEEN_ONE) ? recent_pt : anchor_pt,
                                     recent_pt)};
        if (finishing)
            seen_count = SEEN_NONE;
        if (batch.size() > 0)
            batch[batch.size() - 1].last_of_run = 1'b1;
        due_segments = {due_segments, batch};
    endtask

    // Offers one point, holds it until the transfer, then predicts its segments.
    task automatic send_point(input point_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            point_valid <= 1'b0;
            @(posedge clk);
        end
        point <= p;
        point_valid <= 1'b1;
        do
            @(posedge clk);
        while (point_stall);
        smooth_point(p);
    endtask

    // Receiver: random stall, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            seg_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            seg_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Checks every segment transfer against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && seg_valid === 1'b1 && seg_stall === 1'b0)
        begin
            if (due_segments.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: segment with none predicted: %s", $realtime,
                             seg_text(seg));
            end
            else
            begin
                wanted_seg = due_segments.pop_front();
                if (seg.committed !== wanted_seg.committed ||
                    seg.from_x !== wanted_seg.from_x ||
                    seg.from_y !== wanted_seg.from_y ||
                    seg.from_radius !== wanted_seg.from_radius ||
                    seg.to_x !== wanted_seg.to_x ||
                    seg.to_y !== wanted_seg.to_y ||
                    seg.to_radius !== wanted_seg.to_radius ||
                    seg.last_of_run !== wanted_seg.last_of_run)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: segment differs\n  expected %s\n  actual   %s",
                                 $realtime, seg_text(wanted_seg), seg_text(seg));
                end
            end
        end
    end

    // Stroke openings: finish as the first point, a lone point, repeats,
    // a second distinct point and a finish that adds nothing new.
    task automatic test_stroke_openings();
        send_point(make_point(OP_FINISH, 100, -100, 50, 1'b0));
        send_point(make_point(OP_APPEND, -300, 700, 128, 1'b1));
        send_point(make_point(OP_APPEND, -300, 700, 128, 1'b1));
        send_point(make_point(OP_APPEND, -300, 700, 128, 1'b0));
        send_point(make_point(OP_APPEND, 513, 701, 129, 1'b1));
        send_point(make_point(OP_FINISH, 513, 701, 129, 1'b0));
    endtask

    // Extremes of every field, odd negative sums to exercise rounding down,
    // and a finish that follows the second point with a new one.
    task automatic test_field_extremes();
        send_point(make_point(OP_APPEND, -8388608, -8388608, 0, 1'b0));
        send_point(make_point(OP_APPEND, 8388607, 8388607, 65535, 1'b0));
        send_point(make_point(OP_APPEND, -8388608, 8388607, 65535, 1'b1));
        send_point(make_point(OP_APPEND, 8388607, -8388608, 0, 1'b1));
        send_point(make_point(OP_APPEND, -1, -1, 1, 1'b0));
        send_point(make_point(OP_FINISH, 8388607, 8388607, 65535, 1'b0));
        send_point(make_point(OP_APPEND, -7, 3, 5, 1'b0));
        send_point(make_point(OP_APPEND, -12, -9, 65535, 1'b0));
        send_point(make_point(OP_FINISH, 11, -3, 0, 1'b1));
    endtask

    // Long stroke: the count saturates, with a repeat inside it.
    task automatic test_count_saturation();
        send_point(make_point(OP_APPEND, 1000, 2000, 300, 1'b1));
        send_point(make_point(OP_APPEND, 1301, 2203, 301, 1'b0));
        send_point(make_point(OP_APPEND, 1555, 1999, 297, 1'b1));
        send_point(make_point(OP_APPEND, -2001, -1777, 411, 1'b1));
        send_point(make_point(OP_APPEND, -2001, -1777, 411, 1'b1));
        send_point(make_point(OP_APPEND, -2503, -1000, 90, 1'b0));
        send_point(make_point(OP_FINISH, -2999, 5, 91, 1'b1));
    endtask

    // Random strokes: mostly random walks ending in a finish, with jumps,
    // repeats and the odd stray finish mixed in.
    task automatic test_random_strokes(input int n_items, input int send_pct,
                                       input int recv_pct);
        int     sent;
        int     len;
        int     k;
        int     choice;
        point_t p;
        point_t prev;
        sent = 0;
        prev = '0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (sent < n_items)
        begin
            len = $urandom_range(1, 9);
            for (k = 0; k < len && sent < n_items; k++)
            begin
                choice = $urandom_range(0, 9);
                p = prev;
                if (k == 0 || choice < 2)
                begin
                    p.point_x = 24'($urandom);
                    p.point_y = 24'($urandom);
                    p.point_radius = 16'($urandom);
                end
                else if (choice >= 3)
                begin
                    p.point_x = 24'(prev.point_x + $urandom_range(0, 2047) - 1024);
                    p.point_y = 24'(prev.point_y + $urandom_range(0, 2047) - 1024);
                    p.point_radius = 16'(prev.point_radius + $urandom_range(0, 255) - 128);
                end
                p.op = (k == len - 1) ? OP_FINISH : OP_APPEND;
                if ($urandom_range(0, 9) == 0)
                    p.op = 1'($urandom_range(0, 1));
                p.want_provisional = 1'($urandom_range(0, 1));
                send_point(p);
                prev = p;
                sent++;
            end
        end
    endtask

    // The receiver holds off for a long stretch while points keep coming,
    // so the block fills and stalls its input.
    task automatic test_input_backpressure();
        int k;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 120;
        for (k = 0; k < 14; k++)
            send_point(make_point(k == 13 ? OP_FINISH : OP_APPEND,
                                  k * 777 - 4000, 3000 - k * 513, 200 + k * 3,
                                  k[0]));
    endtask

    // Main sequence.
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 33;
        recv_idle_pct = 80;
        test_stroke_openings();
        test_field_extremes();
        test_count_saturation();
        test_random_strokes(32, 33, 80);
        test_random_strokes(32, 80, 33);
        test_random_strokes(32, 0, 0);
        test_input_backpressure();
        point_valid <= 1'b0;
        while (due_segments.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Run limit.
    initial
    begin
        #1000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
hdl/isms_pkg.sv
hdl/isms_core.sv
hdl/isms_out.sv
hdl/ink_stroke_midpoint_smoother.sv
tb/testbench.sv
